@@ hdl/cgst_pkg.sv @@
// ----------------------------------------------------------------------------
// cgst_pkg
// Shared types, codes and sequence tables of the Clifford gate stream
// transpiler: gate codes, item descriptors and the Toffoli expansion table.
// ----------------------------------------------------------------------------
package cgst_pkg;

    // width of the angle field on the result channel
    localparam int ANG_OUT_W = 16;

    // configuration register indexes
    localparam logic CFG_APPROX = 1'b0;
    localparam logic CFG_STOCH  = 1'b1;

    // gate codes, same on both channels
    typedef enum logic [3:0] {
        G_H    = 4'd0,
        G_X    = 4'd1,
        G_Y    = 4'd2,
        G_Z    = 4'd3,
        G_CNOT = 4'd4,
        G_S    = 4'd5,
        G_CZ   = 4'd6,
        G_SWAP = 4'd7,
        G_MEAS = 4'd8,
        G_T    = 4'd9,
        G_RZ   = 4'd10,
        G_RX   = 4'd11,
        G_RY   = 4'd12,
        G_TOF  = 4'd13
    } gate_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_STRICT = 2'd1,
        ERR_UNSUP  = 2'd2
    } err_t;

    // what the back end does with a queued request
    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_ERR  = 2'd1,
        K_ROT  = 2'd2,
        K_TOF  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        AX_Z = 2'd0,
        AX_X = 2'd1,
        AX_Y = 2'd2
    } axis_t;

    // which Toffoli operand a slot acts on
    typedef enum logic [1:0] {
        Q_C1 = 2'd0,
        Q_C2 = 2'd1,
        Q_T  = 2'd2
    } qsel_t;

    // classified request handed from front to back
    typedef struct packed {
        kind_t      kind;
        axis_t      axis;
        logic [1:0] steps;
        logic [6:0] rz_en;
        err_t       err;
        gate_t      gate;
        logic [1:0] qcnt;
    } desc_t;

    // one slot of the Toffoli expansion
    typedef struct packed {
        logic       is_rz;
        logic       two_q;
        gate_t      gate;
        qsel_t      qa_sel;
        qsel_t      qb_sel;
        logic [2:0] coin;
        logic       tm;
    } tof_slot_t;

    localparam logic [3:0] TOF_LAST_SLOT = 4'd14;
    // inner rotations that are T-dagger (seven eighths of a turn), by coin index
    localparam logic [6:0] TOF_TM_MASK = 7'b1000101;

    // number of gates of a snapped rotation
    function automatic logic [2:0] rot_len(axis_t axis, logic [1:0] steps);
        logic [2:0] n;
        n = 3'd0;
        case (axis)
            AX_Z: begin
                case (steps)
                    2'd1: n = 3'd1;
                    2'd2: n = 3'd1;
                    2'd3: n = 3'd2;
                    default: n = 3'd0;
                endcase
            end
            AX_X: begin
                case (steps)
                    2'd1: n = 3'd3;
                    2'd2: n = 3'd1;
                    2'd3: n = 3'd4;
                    default: n = 3'd0;
                endcase
            end
            AX_Y: begin
                case (steps)
                    2'd1: n = 3'd3;
                    2'd2: n = 3'd1;
                    2'd3: n = 3'd5;
                    default: n = 3'd0;
                endcase
            end
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // gate at a position of a snapped rotation sequence
    function automatic gate_t rot_gate(axis_t axis, logic [1:0] steps, logic [2:0] pos);
        gate_t g;
        g = G_H;
        case (axis)
            AX_Z: begin
                case (steps)
                    2'd1: g = G_S;
                    2'd2: g = G_Z;
                    2'd3: g = (pos == 3'd0) ? G_Z : G_S;
                    default: g = G_H;
                endcase
            end
            AX_X: begin
                case (steps)
                    2'd1: g = (pos == 3'd1) ? G_S : G_H;
                    2'd2: g = G_X;
                    2'd3: begin
                        case (pos)
                            3'd1: g = G_Z;
                            3'd2: g = G_S;
                            default: g = G_H;
                        endcase
                    end
                    default: g = G_H;
                endcase
            end
            AX_Y: begin
                case (steps)
                    2'd1: g = (pos == 3'd1) ? G_H : G_S;
                    2'd2: g = G_Y;
                    2'd3: begin
                        case (pos)
                            3'd0: g = G_Z;
                            3'd1: g = G_S;
                            3'd2: g = G_H;
                            3'd3: g = G_Z;
                            default: g = G_S;
                        endcase
                    end
                    default: g = G_H;
                endcase
            end
            default: g = G_H;
        endcase
        return g;
    endfunction

    // Toffoli expansion: fixed gates and the seven inner z rotations
    function automatic tof_slot_t tof_slot(logic [3:0] slot);
        tof_slot_t s;
        s = '{is_rz: 1'b0, two_q: 1'b1, gate: G_CNOT, qa_sel: Q_C1, qb_sel: Q_C2,
              coin: 3'd0, tm: 1'b0};
        case (slot)
            4'd0:  s = '{1'b0, 1'b0, G_H,    Q_T,  Q_T,  3'd0, 1'b0};
            4'd1:  s = '{1'b0, 1'b1, G_CNOT, Q_C2, Q_T,  3'd0, 1'b0};
            4'd2:  s = '{1'b1, 1'b0, G_S,    Q_T,  Q_T,  3'd0, 1'b1};
            4'd3:  s = '{1'b0, 1'b1, G_CNOT, Q_C1, Q_T,  3'd0, 1'b0};
            4'd4:  s = '{1'b1, 1'b0, G_S,    Q_T,  Q_T,  3'd1, 1'b0};
            4'd5:  s = '{1'b0, 1'b1, G_CNOT, Q_C2, Q_T,  3'd0, 1'b0};
            4'd6:  s = '{1'b1, 1'b0, G_S,    Q_T,  Q_T,  3'd2, 1'b1};
            4'd7:  s = '{1'b0, 1'b1, G_CNOT, Q_C1, Q_T,  3'd0, 1'b0};
            4'd8:  s = '{1'b1, 1'b0, G_S,    Q_C2, Q_C2, 3'd3, 1'b0};
            4'd9:  s = '{1'b1, 1'b0, G_S,    Q_T,  Q_T,  3'd4, 1'b0};
            4'd10: s = '{1'b0, 1'b0, G_H,    Q_T,  Q_T,  3'd0, 1'b0};
            4'd11: s = '{1'b0, 1'b1, G_CNOT, Q_C1, Q_C2, 3'd0, 1'b0};
            4'd12: s = '{1'b1, 1'b0, G_S,    Q_C1, Q_C1, 3'd5, 1'b0};
            4'd13: s = '{1'b1, 1'b0, G_S,    Q_C2, Q_C2, 3'd6, 1'b1};
            4'd14: s = '{1'b0, 1'b1, G_CNOT, Q_C1, Q_C2, 3'd0, 1'b0};
            default: s = '{1'b0, 1'b1, G_CNOT, Q_C1, Q_C2, 3'd0, 1'b0};
        endcase
        return s;
    endfunction

endpackage

@@ hdl/clifford_gate_stream_transpiler_unit.sv @@
// ----------------------------------------------------------------------------
// clifford_gate_stream_transpiler_unit
// Rewrites a stream of quantum gates into Clifford gates: pass-through,
// quarter-turn snapping of rotations, and Toffoli expansion.
// ----------------------------------------------------------------------------
// Usage
//   s_* stream: one gate per request, gate type in s_tuser.
//   m_* stream: one Clifford gate per request, m_tlast on the final gate
//   caused by an input; gate type in m_tuser.
//   cfg_* port: register 0 approximate mode (reset 1), register 1 stochastic
//   mode (reset 0); write only while the block is idle.
// Timing
//   An input is classified in the cycle it is taken and queued; its first
//   result then passes the queue and the registered result stage. The
//   back-end sequencer gives at most one result gate per cycle while m_tready
//   does not hold it; a Toffoli walks every slot of its expansion, whether the
//   inner rotation emits or not, and each inner T-dagger that snaps to three
//   quarter turns emits two gates. Rotations that snap to zero are dropped in
//   the front end and never reach the back end.
// Reset and stall
//   aresetn clears the queue, the sequencer and the result stage. While
//   m_tready is low and the result stage is full the sequencer holds; the
//   two-entry queue keeps taking inputs until full, then s_tready falls.
// ----------------------------------------------------------------------------
module clifford_gate_stream_transpiler_unit #(
    parameter int QUBIT_BITS = 6,
    parameter int ANGLE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // s_tdata: qubit_count, qubit_a, qubit_b, qubit_c, angle_turns, random_bits
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [((2+3*QUBIT_BITS+ANGLE_BITS+8+7)/8)*8-1:0] s_tdata,
    // s_tuser: gate_type
    input  logic [3:0]                                     s_tuser,

    // m_tdata: out_qubit_count, out_qubit_a, out_qubit_b, out_qubit_c,
    //          out_angle, error_code
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    output logic [((2+3*QUBIT_BITS+16+2+7)/8)*8-1:0]       m_tdata,
    output logic                                           m_tlast,
    // m_tuser: out_gate_type
    output logic [3:0]                                     m_tuser,

    input  logic                                           cfg_wr_en,
    input  logic                                           cfg_index,
    input  logic                                           cfg_data
);
    import cgst_pkg::*;

    localparam int M_RAW_W   = 2 + 3*QUBIT_BITS + ANG_OUT_W + 2;
    localparam int M_TDATA_W = ((M_RAW_W+7)/8)*8;
    localparam int QA_LO     = 2;
    localparam int QB_LO     = QA_LO + QUBIT_BITS;
    localparam int QC_LO     = QB_LO + QUBIT_BITS;
    localparam int ANG_LO    = QC_LO + QUBIT_BITS;
    localparam int RB_LO     = ANG_LO + ANGLE_BITS;
    localparam int ENTRY_W   = $bits(desc_t) + 3*QUBIT_BITS + ANG_OUT_W;

    logic approx_mode_reg, approx_mode_next;
    logic stoch_mode_reg, stoch_mode_next;

    desc_t                 f_desc;
    logic [QUBIT_BITS-1:0] f_qa, f_qb, f_qc;
    logic [ANG_OUT_W-1:0]  f_angle;
    logic                  f_keep;
    logic                  accept;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_empty;
    logic                  q_full;
    logic [ENTRY_W-1:0]    q_head;

    desc_t                 b_desc;
    logic [QUBIT_BITS-1:0] b_qa, b_qb, b_qc;
    logic [ANG_OUT_W-1:0]  b_angle;

    gate_t                 o_gate;
    logic [1:0]            o_qcnt;
    logic [QUBIT_BITS-1:0] o_qa, o_qb, o_qc;
    logic [ANG_OUT_W-1:0]  o_angle;
    err_t                  o_err;

    // configuration registers
    always_comb begin
        approx_mode_next = approx_mode_reg;
        stoch_mode_next  = stoch_mode_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_APPROX: approx_mode_next = cfg_data;
                CFG_STOCH:  stoch_mode_next  = cfg_data;
                default:    approx_mode_next = approx_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            approx_mode_reg <= 1'b1;
            stoch_mode_reg  <= 1'b0;
        end else begin
            approx_mode_reg <= approx_mode_next;
            stoch_mode_reg  <= stoch_mode_next;
        end
    end

    // front end: classify and queue
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && f_keep;

    cgst_front #(
        .QUBIT_BITS (QUBIT_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .approx_mode (approx_mode_reg),
        .stoch_mode  (stoch_mode_reg),
        .gate_type   (s_tuser),
        .qubit_count (s_tdata[1:0]),
        .qubit_a     (s_tdata[QA_LO +: QUBIT_BITS]),
        .qubit_b     (s_tdata[QB_LO +: QUBIT_BITS]),
        .qubit_c     (s_tdata[QC_LO +: QUBIT_BITS]),
        .angle_turns (s_tdata[ANG_LO +: ANGLE_BITS]),
        .random_bits (s_tdata[RB_LO +: 8]),
        .desc        (f_desc),
        .desc_qa     (f_qa),
        .desc_qb     (f_qb),
        .desc_qc     (f_qc),
        .desc_angle  (f_angle),
        .keep        (f_keep)
    );

    cgst_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_desc, f_qa, f_qb, f_qc, f_angle}),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {b_desc, b_qa, b_qb, b_qc, b_angle} = q_head;

    // back end: expand into gates
    cgst_back #(
        .QUBIT_BITS (QUBIT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (b_desc),
        .head_qa    (b_qa),
        .head_qb    (b_qb),
        .head_qc    (b_qc),
        .head_angle (b_angle),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_gate     (o_gate),
        .m_qcnt     (o_qcnt),
        .m_qa       (o_qa),
        .m_qb       (o_qb),
        .m_qc       (o_qc),
        .m_angle    (o_angle),
        .m_err      (o_err),
        .m_last     (m_tlast)
    );

    // result packing
    assign m_tuser = o_gate;
    assign m_tdata = M_TDATA_W'({o_err, o_angle, o_qc, o_qb, o_qa, o_qcnt});

endmodule

@@ hdl/cgst_front.sv @@
// ----------------------------------------------------------------------------
// cgst_front
// Classifies one incoming gate: pass-through, error, snapped rotation or
// Toffoli, and resolves every quarter-turn snap of the item.
// ----------------------------------------------------------------------------
module cgst_front #(
    parameter int QUBIT_BITS = 6,
    parameter int ANGLE_BITS = 16
) (
    input  logic                     approx_mode,
    input  logic                     stoch_mode,
    input  logic [3:0]               gate_type,
    input  logic [1:0]               qubit_count,
    input  logic [QUBIT_BITS-1:0]    qubit_a,
    input  logic [QUBIT_BITS-1:0]    qubit_b,
    input  logic [QUBIT_BITS-1:0]    qubit_c,
    input  logic [ANGLE_BITS-1:0]    angle_turns,
    input  logic [7:0]               random_bits,
    output cgst_pkg::desc_t          desc,
    output logic [QUBIT_BITS-1:0]    desc_qa,
    output logic [QUBIT_BITS-1:0]    desc_qb,
    output logic [QUBIT_BITS-1:0]    desc_qc,
    output logic [cgst_pkg::ANG_OUT_W-1:0] desc_angle,
    output logic                     keep
);
    import cgst_pkg::*;

    localparam int AW = (ANGLE_BITS < ANG_OUT_W) ? ANGLE_BITS : ANG_OUT_W;
    localparam logic [ANGLE_BITS-3:0] HALF = {1'b1, {(ANGLE_BITS-3){1'b0}}};

    logic [1:0]            fl;
    logic [ANGLE_BITS-3:0] fr;
    logic                  round_up;
    logic [1:0]            ang_steps;
    logic [1:0]            t_steps;

    // nearest quarter turn of the angle, halfway by coin or to even
    assign fl = angle_turns[ANGLE_BITS-1 -: 2];
    assign fr = angle_turns[ANGLE_BITS-3:0];
    always_comb begin
        if (fr == HALF) begin
            round_up = stoch_mode ? random_bits[0] : fl[0];
        end else begin
            round_up = (fr > HALF);
        end
    end
    assign ang_steps = fl + {1'b0, round_up};
    // T is one eighth turn: always halfway between zero and one step
    assign t_steps = {1'b0, stoch_mode & random_bits[0]};

    // classification
    always_comb begin
        desc.kind  = K_ERR;
        desc.axis  = AX_Z;
        desc.steps = 2'd0;
        desc.rz_en = '0;
        desc.err   = ERR_NONE;
        desc.gate  = gate_t'(gate_type);
        desc.qcnt  = qubit_count;
        desc_qa    = qubit_a;
        desc_qb    = qubit_b;
        desc_qc    = qubit_c;
        desc_angle = ANG_OUT_W'(angle_turns[AW-1:0]);
        case (gate_type) inside
            [G_H:G_MEAS]: begin
                desc.kind = K_PASS;
                desc_qa   = (qubit_count > 2'd0) ? qubit_a : '0;
                desc_qb   = (qubit_count > 2'd1) ? qubit_b : '0;
                desc_qc   = (qubit_count > 2'd2) ? qubit_c : '0;
            end
            default: begin
                if (!approx_mode) begin
                    desc.kind = K_ERR;
                    desc.err  = ERR_STRICT;
                end else begin
                    case (gate_type) inside
                        G_T: begin
                            desc.kind  = K_ROT;
                            desc.axis  = AX_Z;
                            desc.steps = t_steps;
                        end
                        G_RZ: begin
                            desc.kind  = K_ROT;
                            desc.axis  = AX_Z;
                            desc.steps = ang_steps;
                        end
                        G_RX: begin
                            desc.kind  = K_ROT;
                            desc.axis  = AX_X;
                            desc.steps = ang_steps;
                        end
                        G_RY: begin
                            desc.kind  = K_ROT;
                            desc.axis  = AX_Y;
                            desc.steps = ang_steps;
                        end
                        G_TOF: begin
                            // inner rotation k is nonzero when its coin leaves it off zero
                            desc.kind  = K_TOF;
                            desc.rz_en = {7{stoch_mode}} &
                                         (TOF_TM_MASK ^ random_bits[6:0]);
                        end
                        default: begin
                            desc.kind = K_ERR;
                            desc.err  = ERR_UNSUP;
                        end
                    endcase
                end
            end
        endcase
    end

    // a rotation that snaps to zero produces nothing
    assign keep = !((desc.kind == K_ROT) && (desc.steps == 2'd0));

endmodule

@@ hdl/cgst_fifo.sv @@
// ----------------------------------------------------------------------------
// cgst_fifo
// Two-entry first-word-fall-through queue between front and back end.
// ----------------------------------------------------------------------------
module cgst_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);
    import cgst_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/cgst_back.sv @@
// ----------------------------------------------------------------------------
// cgst_back
// Sequencer that turns one queued request into its Clifford gates, at most
// one gate per cycle while the registered result stage can take it.
// ----------------------------------------------------------------------------
module cgst_back #(
    parameter int QUBIT_BITS = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cgst_pkg::desc_t                head,
    input  logic [QUBIT_BITS-1:0]          head_qa,
    input  logic [QUBIT_BITS-1:0]          head_qb,
    input  logic [QUBIT_BITS-1:0]          head_qc,
    input  logic [cgst_pkg::ANG_OUT_W-1:0] head_angle,
    input  logic                           head_empty,
    output logic                           head_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cgst_pkg::gate_t                m_gate,
    output logic [1:0]                     m_qcnt,
    output logic [QUBIT_BITS-1:0]          m_qa,
    output logic [QUBIT_BITS-1:0]          m_qb,
    output logic [QUBIT_BITS-1:0]          m_qc,
    output logic [cgst_pkg::ANG_OUT_W-1:0] m_angle,
    output cgst_pkg::err_t                 m_err,
    output logic                           m_last
);
    import cgst_pkg::*;

    logic [3:0]            slot_reg, slot_next;
    logic [2:0]            pos_reg, pos_next;
    logic                  valid_reg, valid_next;
    gate_t                 gate_reg;
    logic [1:0]            qcnt_reg;
    logic [QUBIT_BITS-1:0] qa_reg, qb_reg, qc_reg;
    logic [ANG_OUT_W-1:0]  angle_reg;
    err_t                  err_reg;
    logic                  last_reg;

    tof_slot_t             ts;
    logic [1:0]            rz_steps;
    logic [2:0]            seq_len;
    logic                  step;
    logic                  emit;
    logic                  last;
    logic                  seg_end;
    gate_t                 o_gate;
    logic [1:0]            o_qcnt;
    logic [QUBIT_BITS-1:0] o_qa, o_qb, o_qc;
    logic [ANG_OUT_W-1:0]  o_angle;
    err_t                  o_err;

    // pick a Toffoli operand
    function automatic logic [QUBIT_BITS-1:0] pick(qsel_t sel, logic [QUBIT_BITS-1:0] c1,
                                                   logic [QUBIT_BITS-1:0] c2,
                                                   logic [QUBIT_BITS-1:0] t);
        logic [QUBIT_BITS-1:0] q;
        case (sel)
            Q_C1:    q = c1;
            Q_C2:    q = c2;
            default: q = t;
        endcase
        return q;
    endfunction

    // advance whenever a request waits and the result stage can take a gate
    assign step = !head_empty && (!valid_reg || m_ready);

    // gate for the current position of the request
    always_comb begin
        ts       = tof_slot(slot_reg);
        rz_steps = ts.tm ? 2'd3 : 2'd1;
        seq_len  = 3'd1;
        emit     = 1'b0;
        last     = 1'b0;
        seg_end  = 1'b1;
        o_gate   = G_H;
        o_qcnt   = 2'd0;
        o_qa     = '0;
        o_qb     = '0;
        o_qc     = '0;
        o_angle  = '0;
        o_err    = ERR_NONE;
        case (head.kind)
            K_PASS: begin
                emit    = 1'b1;
                last    = 1'b1;
                o_gate  = head.gate;
                o_qcnt  = head.qcnt;
                o_qa    = head_qa;
                o_qb    = head_qb;
                o_qc    = head_qc;
                o_angle = head_angle;
            end
            K_ERR: begin
                emit  = 1'b1;
                last  = 1'b1;
                o_err = head.err;
            end
            K_ROT: begin
                seq_len = rot_len(head.axis, head.steps);
                emit    = 1'b1;
                last    = (pos_reg == seq_len - 3'd1);
                o_gate  = rot_gate(head.axis, head.steps, pos_reg);
                o_qcnt  = 2'd1;
                o_qa    = head_qa;
            end
            K_TOF: begin
                last = (slot_reg == TOF_LAST_SLOT);
                if (ts.is_rz) begin
                    // inner z rotation: skipped when it snapped to zero
                    seq_len = rot_len(AX_Z, rz_steps);
                    if (head.rz_en[ts.coin]) begin
                        emit    = 1'b1;
                        seg_end = (pos_reg == seq_len - 3'd1);
                        o_gate  = rot_gate(AX_Z, rz_steps, pos_reg);
                        o_qcnt  = 2'd1;
                        o_qa    = pick(ts.qa_sel, head_qa, head_qb, head_qc);
                    end
                end else begin
                    emit   = 1'b1;
                    o_gate = ts.gate;
                    o_qcnt = ts.two_q ? 2'd2 : 2'd1;
                    o_qa   = pick(ts.qa_sel, head_qa, head_qb, head_qc);
                    o_qb   = ts.two_q ? pick(ts.qb_sel, head_qa, head_qb, head_qc) : '0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign head_pop = step && emit && last;

    // sequence position
    always_comb begin
        slot_next = slot_reg;
        pos_next  = pos_reg;
        if (step) begin
            if (emit && last) begin
                slot_next = 4'd0;
                pos_next  = 3'd0;
            end else if (head.kind == K_TOF) begin
                if (seg_end) begin
                    slot_next = slot_reg + 4'd1;
                    pos_next  = 3'd0;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    // result stage valid
    always_comb begin
        valid_next = valid_reg;
        if (step && emit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= 4'd0;
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (step && emit) begin
            gate_reg  <= o_gate;
            qcnt_reg  <= o_qcnt;
            qa_reg    <= o_qa;
            qb_reg    <= o_qb;
            qc_reg    <= o_qc;
            angle_reg <= o_angle;
            err_reg   <= o_err;
            last_reg  <= last;
        end
    end

    assign m_valid = valid_reg;
    assign m_gate  = gate_reg;
    assign m_qcnt  = qcnt_reg;
    assign m_qa    = qa_reg;
    assign m_qb    = qb_reg;
    assign m_qc    = qc_reg;
    assign m_angle = angle_reg;
    assign m_err   = err_reg;
    assign m_last  = last_reg;

endmodule

@@ sim/tb_clifford_gate_stream_transpiler_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clifford_gate_stream_transpiler_unit
// Self-checking bench for the Clifford gate stream transpiler. A short
// directed table covers every gate type, the snapping corner cases and the
// error paths; random phases follow under all mode settings. Each accepted
// request is run through a local transpiler model or given a fixed expected
// result, and every result gate is compared field by field, with random gaps
// on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_clifford_gate_stream_transpiler_unit;
    import cgst_pkg::*;

    localparam int QW = 6;
    localparam int AW = 16;
    localparam int SW = ((2+3*QW+AW+8+7)/8)*8;
    localparam int MW = ((2+3*QW+16+2+7)/8)*8;
    localparam logic [AW-1:0] EIGHTH_TURN     = 16'h2000;
    localparam logic [AW-1:0] EIGHTH_TURN_NEG = 16'hE000;
    localparam logic [3:0] G_RSVD_LO = 4'd14;
    localparam logic [3:0] G_RSVD_HI = 4'd15;
    // error results carry a zero gate code
    localparam logic [3:0] NO_GATE = 4'd0;
    // covers the queue, a full Toffoli pass and the output stage
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 58;

    typedef struct packed {
        logic [3:0]    gate;
        logic [1:0]    cnt;
        logic [QW-1:0] qa;
        logic [QW-1:0] qb;
        logic [QW-1:0] qc;
        logic [AW-1:0] ang;
        logic [7:0]    coins;
    } gate_req_t;

    typedef struct packed {
        logic [3:0]    gate;
        logic [1:0]    cnt;
        logic [QW-1:0] qa;
        logic [QW-1:0] qb;
        logic [QW-1:0] qc;
        logic [15:0]   ang;
        logic [1:0]    err;
        logic          last;
    } gate_res_t;

    typedef enum int {
        ROW_GATE,
        ROW_KNOWN,
        ROW_MODES
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        gate_req_t req;
        gate_res_t res;
        bit        approx;
        bit        stoch;
    } stim_row_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata   = '0;
    logic [3:0]    s_tuser   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [MW-1:0] m_tdata;
    logic          m_tlast;
    logic [3:0]    m_tuser;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_index = 1'b0;
    logic          cfg_data  = 1'b0;

    clifford_gate_stream_transpiler_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model copy of the mode registers
    bit mdl_approx = 1'b1;
    bit mdl_stoch  = 1'b0;

    gate_res_t   pending_gates[$];
    stim_row_t   stim_rows[$];
    int unsigned coin_pos;
    logic [7:0]  coin_word;
    int          error_count    = 0;
    int          src_gap_pct    = 0;
    int          sink_stall_pct = 0;
    int          stall_left     = 0;
    gate_res_t   want;

    // ------------------------------------------------------------------
    // transpiler model
    // ------------------------------------------------------------------

    // nearest quarter turn, modulo four; halfway by parity or by coin
    function automatic logic [1:0] snap_quarters(logic [AW-1:0] ang);
        logic [1:0]    fl;
        logic [AW-3:0] fr;
        logic [AW-3:0] half;
        logic [1:0]    r;
        fl   = ang[AW-1:AW-2];
        fr   = ang[AW-3:0];
        half = {1'b1, {(AW-3){1'b0}}};
        if (fr == half) begin
            if (mdl_stoch) begin
                r = fl + ((coin_pos < 8) ? coin_word[coin_pos] : 1'b0);
            end else begin
                r = fl[0] ? fl + 2'd1 : fl;
            end
            coin_pos++;
        end else begin
            r = (fr > half) ? fl + 2'd1 : fl;
        end
        return r;
    endfunction

    task automatic emit_gate(logic [3:0] g, logic [1:0] cnt, logic [QW-1:0] a,
                             logic [QW-1:0] b, logic [QW-1:0] c, logic [15:0] ang,
                             logic [1:0] err);
        gate_res_t r;
        r = '{gate: g, cnt: cnt, qa: a, qb: b, qc: c, ang: ang, err: err, last: 1'b0};
        pending_gates = {pending_gates, r};
    endtask

    task automatic emit_single(logic [3:0] g, logic [QW-1:0] q);
        emit_gate(g, 2'd1, q, '0, '0, '0, ERR_NONE);
    endtask

    task automatic emit_cnot(logic [QW-1:0] c, logic [QW-1:0] t);
        emit_gate(G_CNOT, 2'd2, c, t, '0, '0, ERR_NONE);
    endtask

    // clifford sequence of a snapped rotation
    task automatic emit_rotation(axis_t ax, logic [QW-1:0] q, logic [1:0] s);
        case (ax)
            AX_Z: begin
                case (s)
                    2'd1: emit_single(G_S, q);
                    2'd2: emit_single(G_Z, q);
                    2'd3: begin
                        emit_single(G_Z, q); emit_single(G_S, q);
                    end
                    default: ;
                endcase
            end
            AX_X: begin
                case (s)
                    2'd1: begin
                        emit_single(G_H, q); emit_single(G_S, q); emit_single(G_H, q);
                    end
                    2'd2: emit_single(G_X, q);
                    2'd3: begin
                        emit_single(G_H, q); emit_single(G_Z, q);
                        emit_single(G_S, q); emit_single(G_H, q);
                    end
                    default: ;
                endcase
            end
            default: begin
                case (s)
                    2'd1: begin
                        emit_single(G_S, q); emit_single(G_H, q); emit_single(G_S, q);
                    end
                    2'd2: emit_single(G_Y, q);
                    2'd3: begin
                        emit_single(G_Z, q); emit_single(G_S, q); emit_single(G_H, q);
                        emit_single(G_Z, q); emit_single(G_S, q);
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    // fixed 15-gate toffoli network, inner T / T-dagger snapped as rz
    task automatic expand_toffoli(logic [QW-1:0] c1, logic [QW-1:0] c2, logic [QW-1:0] t);
        emit_single(G_H, t);
        emit_cnot(c2, t);
        emit_rotation(AX_Z, t, snap_quarters(EIGHTH_TURN_NEG));
        emit_cnot(c1, t);
        emit_rotation(AX_Z, t, snap_quarters(EIGHTH_TURN));
        emit_cnot(c2, t);
        emit_rotation(AX_Z, t, snap_quarters(EIGHTH_TURN_NEG));
        emit_cnot(c1, t);
        emit_rotation(AX_Z, c2, snap_quarters(EIGHTH_TURN));
        emit_rotation(AX_Z, t, snap_quarters(EIGHTH_TURN));
        emit_single(G_H, t);
        emit_cnot(c1, c2);
        emit_rotation(AX_Z, c1, snap_quarters(EIGHTH_TURN));
        emit_rotation(AX_Z, c2, snap_quarters(EIGHTH_TURN_NEG));
        emit_cnot(c1, c2);
    endtask

    // expected result gates of one request, appended to pending_gates
    task automatic transpile_gate(gate_req_t r);
        int n0;
        n0        = pending_gates.size();
        coin_word = r.coins;
        coin_pos  = 0;
        if (r.gate <= G_MEAS) begin
            emit_gate(r.gate, r.cnt, (r.cnt > 0) ? r.qa : '0, (r.cnt > 1) ? r.qb : '0,
                      (r.cnt > 2) ? r.qc : '0, r.ang, ERR_NONE);
        end else if (!mdl_approx) begin
            emit_gate(NO_GATE, 2'd0, '0, '0, '0, '0, ERR_STRICT);
        end else begin
            case (r.gate)
                G_T:   emit_rotation(AX_Z, r.qa, snap_quarters(EIGHTH_TURN));
                G_RZ:  emit_rotation(AX_Z, r.qa, snap_quarters(r.ang));
                G_RX:  emit_rotation(AX_X, r.qa, snap_quarters(r.ang));
                G_RY:  emit_rotation(AX_Y, r.qa, snap_quarters(r.ang));
                G_TOF: expand_toffoli(r.qa, r.qb, r.qc);
                default: emit_gate(NO_GATE, 2'd0, '0, '0, '0, '0, ERR_UNSUP);
            endcase
        end
        // flag the final gate of this request
        if (pending_gates.size() > n0) begin
            pending_gates[$].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic gate_req_t mk_req(logic [3:0] g, logic [1:0] cnt, logic [QW-1:0] a,
                                         logic [QW-1:0] b, logic [QW-1:0] c,
                                         logic [AW-1:0] ang, logic [7:0] coins);
        gate_req_t r;
        r = '{gate: g, cnt: cnt, qa: a, qb: b, qc: c, ang: ang, coins: coins};
        return r;
    endfunction

    // single-result expectation, so it is the last of its run
    function automatic gate_res_t mk_res(logic [3:0] g, logic [1:0] cnt, logic [QW-1:0] a,
                                         logic [QW-1:0] b, logic [QW-1:0] c,
                                         logic [15:0] ang, logic [1:0] err);
        gate_res_t r;
        r = '{gate: g, cnt: cnt, qa: a, qb: b, qc: c, ang: ang, err: err, last: 1'b1};
        return r;
    endfunction

    task automatic add_gate(gate_req_t req);
        stim_row_t row;
        row.kind = ROW_GATE;
        row.req  = req;
        stim_rows = {stim_rows, row};
    endtask

    task automatic add_known(gate_req_t req, gate_res_t res);
        stim_row_t row;
        row.kind = ROW_KNOWN;
        row.req  = req;
        row.res  = res;
        stim_rows = {stim_rows, row};
    endtask

    task automatic add_modes(bit approx, bit stoch);
        stim_row_t row;
        row.kind   = ROW_MODES;
        row.approx = approx;
        row.stoch  = stoch;
        stim_rows = {stim_rows, row};
    endtask

    function automatic gate_req_t random_gate();
        gate_req_t r;
        int        pick;
        int        offs;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.gate = 4'($urandom_range(G_H, G_MEAS));
        end else if (pick < 65) begin
            r.gate = 4'($urandom_range(G_T, G_RY));
        end else if (pick < 85) begin
            r.gate = G_TOF;
        end else begin
            r.gate = 4'($urandom_range(0, 15));
        end
        r.cnt   = 2'($urandom_range(0, 3));
        r.qa    = QW'($urandom_range(0, 63));
        r.qb    = QW'($urandom_range(0, 63));
        r.qc    = QW'($urandom_range(0, 63));
        r.coins = 8'($urandom_range(0, 255));
        // half the angles sit on or next to an eighth-turn boundary
        if ($urandom_range(0, 1) == 0) begin
            r.ang = AW'($urandom_range(0, 65535));
        end else begin
            pick = $urandom_range(0, 4);
            offs = (pick == 0) ? -1 : (pick == 1) ? 1 : 0;
            r.ang = AW'($urandom_range(0, 7) * 8192 + offs);
        end
        return r;
    endfunction

    // one request: optional gap, then hold until accepted
    task automatic send_gate(gate_req_t r, bit known, gate_res_t res);
        int            gap;
        logic [SW-1:0] d;
        gap = 0;
        if ($urandom_range(0, 99) < src_gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        d = SW'({r.coins, r.ang, r.qc, r.qb, r.qa, r.cnt});
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= r.gate;
        do @(posedge aclk); while (!s_tready);
        if (known) begin
            pending_gates = {pending_gates, res};
        end else begin
            transpile_gate(r);
        end
    endtask

    // mode change only once the block has drained
    task automatic set_modes(bit approx, bit stoch);
        s_tvalid <= 1'b0;
        while (pending_gates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_APPROX;
        cfg_data  <= approx;
        @(posedge aclk);
        cfg_index <= CFG_STOCH;
        cfg_data  <= stoch;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        mdl_approx = approx;
        mdl_stoch  = stoch;
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // result checker and back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_gates.size() == 0) begin
                    $error("unexpected result request: gate %0d", m_tuser);
                    error_count++;
                end else begin
                    want = pending_gates.pop_front();
                    check_field("out_gate_type", want.gate, m_tuser);
                    check_field("out_qubit_count", want.cnt, m_tdata[1:0]);
                    check_field("out_qubit_a", want.qa, m_tdata[7:2]);
                    check_field("out_qubit_b", want.qb, m_tdata[13:8]);
                    check_field("out_qubit_c", want.qc, m_tdata[19:14]);
                    check_field("out_angle", want.ang, m_tdata[35:20]);
                    check_field("error_code", want.err, m_tdata[37:36]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
            // random stalls, mostly short
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // reset modes: approximate, half to even
        add_known(mk_req(G_H, 2'd3, 6'd63, 6'd63, 6'd63, 16'hFFFF, 8'hFF),
                  mk_res(G_H, 2'd3, 6'd63, 6'd63, 6'd63, 16'hFFFF, ERR_NONE));
        add_known(mk_req(G_MEAS, 2'd0, 6'd63, 6'd63, 6'd63, 16'h8001, 8'h00),
                  mk_res(G_MEAS, 2'd0, 6'd0, 6'd0, 6'd0, 16'h8001, ERR_NONE));
        add_known(mk_req(G_CNOT, 2'd2, 6'd5, 6'd9, 6'd63, 16'h0000, 8'h00),
                  mk_res(G_CNOT, 2'd2, 6'd5, 6'd9, 6'd0, 16'h0000, ERR_NONE));
        add_gate(mk_req(G_X, 2'd1, 6'd0, 6'd7, 6'd7, 16'h1234, 8'h00));
        add_gate(mk_req(G_Y, 2'd1, 6'd63, 6'd1, 6'd2, 16'h0001, 8'h00));
        add_gate(mk_req(G_Z, 2'd2, 6'd17, 6'd42, 6'd3, 16'h7FFF, 8'h00));
        add_gate(mk_req(G_S, 2'd1, 6'd33, 6'd0, 6'd0, 16'h4000, 8'h00));
        add_gate(mk_req(G_CZ, 2'd2, 6'd12, 6'd13, 6'd14, 16'h0000, 8'h00));
        add_gate(mk_req(G_SWAP, 2'd3, 6'd21, 6'd42, 6'd63, 16'hAAAA, 8'h00));
        // T snaps to zero under half to even: no result at all
        add_gate(mk_req(G_T, 2'd1, 6'd8, 6'd0, 6'd0, 16'h0000, 8'hFF));
        add_gate(mk_req(G_RZ, 2'd1, 6'd9, 6'd0, 6'd0, 16'hC000, 8'h00));
        // exact halfway from an odd quarter rounds up
        add_gate(mk_req(G_RZ, 2'd1, 6'd10, 6'd0, 6'd0, 16'h6000, 8'h00));
        // just under a full turn wraps to zero steps
        add_gate(mk_req(G_RZ, 2'd0, 6'd11, 6'd0, 6'd0, 16'hFFFF, 8'h00));
        add_gate(mk_req(G_RX, 2'd1, 6'd12, 6'd0, 6'd0, 16'hC000, 8'h00));
        add_gate(mk_req(G_RY, 2'd1, 6'd13, 6'd0, 6'd0, 16'hC000, 8'h00));
        add_gate(mk_req(G_RY, 2'd2, 6'd14, 6'd0, 6'd0, 16'h4000, 8'h00));
        add_gate(mk_req(G_TOF, 2'd1, 6'd0, 6'd63, 6'd21, 16'h0000, 8'hFF));
        add_known(mk_req(G_RSVD_LO, 2'd3, 6'd1, 6'd2, 6'd3, 16'h1111, 8'h00),
                  mk_res(NO_GATE, 2'd0, 6'd0, 6'd0, 6'd0, 16'h0000, ERR_UNSUP));
        // coin-resolved halfway snaps
        add_modes(1'b1, 1'b1);
        add_gate(mk_req(G_TOF, 2'd3, 6'd1, 6'd2, 6'd3, 16'h0000, 8'hFF));
        add_gate(mk_req(G_TOF, 2'd3, 6'd63, 6'd0, 6'd42, 16'h0000, 8'h55));
        add_gate(mk_req(G_T, 2'd1, 6'd5, 6'd0, 6'd0, 16'h0000, 8'h00));
        add_gate(mk_req(G_RX, 2'd1, 6'd6, 6'd0, 6'd0, 16'hA000, 8'h01));
        // strict mode: every non-clifford type is an error
        add_modes(1'b0, 1'b0);
        add_known(mk_req(G_RZ, 2'd1, 6'd7, 6'd0, 6'd0, 16'h4000, 8'h00),
                  mk_res(NO_GATE, 2'd0, 6'd0, 6'd0, 6'd0, 16'h0000, ERR_STRICT));
        add_known(mk_req(G_RSVD_HI, 2'd0, 6'd63, 6'd63, 6'd63, 16'hFFFF, 8'hFF),
                  mk_res(NO_GATE, 2'd0, 6'd0, 6'd0, 6'd0, 16'h0000, ERR_STRICT));
        add_gate(mk_req(G_H, 2'd1, 6'd4, 6'd5, 6'd6, 16'h0F0F, 8'h00));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        src_gap_pct    = 30;
        sink_stall_pct = 20;
        foreach (stim_rows[i]) begin
            case (stim_rows[i].kind)
                ROW_MODES: set_modes(stim_rows[i].approx, stim_rows[i].stoch);
                ROW_KNOWN: send_gate(stim_rows[i].req, 1'b1, stim_rows[i].res);
                default:   send_gate(stim_rows[i].req, 1'b0, '0);
            endcase
        end

        // random phases over all mode settings, with differing idle behavior
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_modes(1'b1, 1'b1);
                1: set_modes(1'b0, 1'b0);
                2: set_modes(1'b1, 1'b0);
                3: set_modes(1'b0, 1'b1);
                4: set_modes(1'b1, 1'b1);
                default: set_modes(1'b1, 1'b0);
            endcase
            src_gap_pct    = (ph == 2) ? 0 : (ph == 4) ? 60 : 25;
            sink_stall_pct = (ph == 2) ? 0 : (ph == 5) ? 50 : 20;
            repeat (PHASE_ITEMS) send_gate(random_gate(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_gates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
